// ----- hw/rtl/pcs_pkg.sv -----
package pcs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam logic [7:0] MAX_SLOTS_RESET = 8'd4;

   localparam logic [1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_CANCEL  = 2'd2;

   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_QUEUED     = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_REL_IDLE   = 3'd3;
   localparam logic [2:0] ST_REL_WAITER = 3'd4;
   localparam logic [2:0] ST_CANCELLED  = 3'd5;
   localparam logic [2:0] ST_ERROR      = 3'd6;

   typedef struct packed {
      logic       load;
      logic       exec;
      logic [2:0] op;
   } pcs_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       free_nz;
      logic       held_nz;
      logic       queue_nz;
      logic       queue_full;
      logic       cancel_hit;
   } pcs_stat_type;

endpackage

// ----- hw/rtl/pcs_ctrl.sv -----
module pcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pcs_pkg::pcs_stat_type stat,
   output pcs_pkg::pcs_cmd_type  cmd
);
   import pcs_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic [2:0] op;

   always_comb begin
      op = ST_ERROR;
      unique case (stat.action)
         ACT_ACQUIRE: begin
            if (stat.free_nz) begin
               op = ST_GRANTED;
            end else if (stat.queue_full) begin
               op = ST_FULL;
            end else begin
               op = ST_QUEUED;
            end
         end
         ACT_RELEASE: begin
            if (!stat.held_nz) begin
               op = ST_ERROR;
            end else if (stat.queue_nz) begin
               op = ST_REL_WAITER;
            end else begin
               op = ST_REL_IDLE;
            end
         end
         ACT_CANCEL: begin
            op = stat.cancel_hit ? ST_CANCELLED : ST_ERROR;
         end
         default: begin
            op = ST_ERROR;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy     = (state_ff == S_EXEC);
   assign cmd.load = start && (state_ff == S_IDLE);
   assign cmd.exec = (state_ff == S_EXEC);
   assign cmd.op   = op;

endmodule

// ----- hw/rtl/pcs_datapath.sv -----
module pcs_datapath #(
   parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pcs_pkg::pcs_cmd_type  cmd,
   output pcs_pkg::pcs_stat_type stat,
   input  logic [1:0]            req_action,
   input  logic [3:0]            req_requester,
   input  logic [7:0]            req_priority_req,
   input  logic                  csr_write_en,
   input  logic [7:0]            csr_write_data,
   output logic                  rsp_strobe,
   output logic [2:0]            rsp_status,
   output logic [3:0]            rsp_granted_requester,
   output logic [7:0]            rsp_available_slots,
   output logic [4:0]            rsp_waiting_total,
   output logic [7:0]            rsp_held_slots
);
   import pcs_pkg::*;

   localparam int LenW = $clog2(QUEUE_DEPTH + 1);

   logic [1:0]      act_ff;
   logic [3:0]      id_ff;
   logic [7:0]      prio_ff;
   logic [7:0]      free_ff;
   logic [7:0]      free_in;
   logic [7:0]      held_ff;
   logic [7:0]      held_in;
   logic [LenW-1:0] len_ff;
   logic [LenW-1:0] len_in;
   logic            ins;
   logic            rem;
   logic [3:0]      granted;

   logic [3:0] ent_id_ff   [QUEUE_DEPTH];
   logic [7:0] ent_prio_ff [QUEUE_DEPTH];
   logic [3:0] ent_id_in   [QUEUE_DEPTH];
   logic [7:0] ent_prio_in [QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0] valid;
   logic [QUEUE_DEPTH-1:0] ge;
   logic [QUEUE_DEPTH-1:0] ge_prev;
   logic [QUEUE_DEPTH-1:0] hit;
   logic [QUEUE_DEPTH-1:0] hit_pre;
   logic [QUEUE_DEPTH-1:0] rem_mask;

   logic       rsp_strobe_ff;
   logic [2:0] rsp_status_ff;
   logic [3:0] rsp_granted_ff;
   logic [7:0] rsp_avail_ff;
   logic [4:0] rsp_wait_ff;
   logic [7:0] rsp_held_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         id_ff   <= req_requester;
         prio_ff <= req_priority_req;
      end
   end

   // Each entry compares itself with the request; the sorted chain then
   // shifts in one step.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
      assign valid[i] = LenW'(i) < len_ff;
      assign ge[i]    = valid[i] && (ent_prio_ff[i] >= prio_ff);
      assign hit[i]   = valid[i] && (ent_id_ff[i] == id_ff);
      if (i == 0) begin : g_first
         assign ge_prev[i] = 1'b1;
      end else begin : g_rest
         assign ge_prev[i] = ge[i-1];
      end
   end

   always_comb begin
      logic [QUEUE_DEPTH-1:0] low_mask;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         for (int j = 0; j < QUEUE_DEPTH; j++) begin
            low_mask[j] = (j <= i);
         end
         hit_pre[i] = |(hit & low_mask);
      end
   end

   assign rem_mask = (cmd.op == ST_REL_WAITER) ? {QUEUE_DEPTH{1'b1}} : hit_pre;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ent
      logic [3:0] prev_id;
      logic [7:0] prev_prio;
      logic [3:0] next_id;
      logic [7:0] next_prio;

      if (i == 0) begin : g_p0
         assign prev_id   = req_requester;
         assign prev_prio = req_priority_req;
      end else begin : g_pn
         assign prev_id   = ent_id_ff[i-1];
         assign prev_prio = ent_prio_ff[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_nl
         assign next_id   = '0;
         assign next_prio = '0;
      end else begin : g_nn
         assign next_id   = ent_id_ff[i+1];
         assign next_prio = ent_prio_ff[i+1];
      end

      always_comb begin
         ent_id_in[i]   = ent_id_ff[i];
         ent_prio_in[i] = ent_prio_ff[i];
         if (ins && !ge[i]) begin
            if (ge_prev[i]) begin
               ent_id_in[i]   = id_ff;
               ent_prio_in[i] = prio_ff;
            end else begin
               ent_id_in[i]   = prev_id;
               ent_prio_in[i] = prev_prio;
            end
         end else if (rem && rem_mask[i]) begin
            ent_id_in[i]   = next_id;
            ent_prio_in[i] = next_prio;
         end
      end

      always_ff @(posedge clock) begin
         ent_id_ff[i]   <= ent_id_in[i];
         ent_prio_ff[i] <= ent_prio_in[i];
      end
   end

   always_comb begin
      free_in = free_ff;
      held_in = held_ff;
      len_in  = len_ff;
      ins     = 1'b0;
      rem     = 1'b0;
      granted = '0;
      if (csr_write_en) begin
         free_in = csr_write_data;
         held_in = '0;
         len_in  = '0;
      end else if (cmd.exec) begin
         unique case (cmd.op)
            ST_GRANTED: begin
               free_in = free_ff - 8'd1;
               if (held_ff != 8'hFF) begin
                  held_in = held_ff + 8'd1;
               end
               granted = id_ff;
            end
            ST_QUEUED: begin
               len_in = len_ff + LenW'(1);
               ins    = 1'b1;
            end
            ST_REL_IDLE: begin
               held_in = held_ff - 8'd1;
               if (free_ff != 8'hFF) begin
                  free_in = free_ff + 8'd1;
               end
            end
            ST_REL_WAITER: begin
               len_in  = len_ff - LenW'(1);
               rem     = 1'b1;
               granted = ent_id_ff[0];
            end
            ST_CANCELLED: begin
               len_in = len_ff - LenW'(1);
               rem    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff       <= MAX_SLOTS_RESET;
         held_ff       <= '0;
         len_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         free_ff       <= free_in;
         held_ff       <= held_in;
         len_ff        <= len_in;
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff  <= cmd.op;
         rsp_granted_ff <= granted;
         rsp_avail_ff   <= free_in;
         rsp_wait_ff    <= 5'(len_in);
         rsp_held_ff    <= held_in;
      end
   end

   assign stat.action     = act_ff;
   assign stat.free_nz    = (free_ff != 8'd0);
   assign stat.held_nz    = (held_ff != 8'd0);
   assign stat.queue_nz   = (len_ff != '0);
   assign stat.queue_full = (len_ff == LenW'(QUEUE_DEPTH));
   assign stat.cancel_hit = |hit;

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_granted_requester = rsp_granted_ff;
   assign rsp_available_slots   = rsp_avail_ff;
   assign rsp_waiting_total     = rsp_wait_ff;
   assign rsp_held_slots        = rsp_held_ff;

endmodule

// ----- hw/rtl/priority_counting_semaphore_top.sv -----
// A request accepted while idle is registered and then executed in the execute state,
// and its result is registered onto the rsp_ ports, with rsp_strobe high.
// A new request is not taken while busy; busy is high for the one execute cycle.
// The sorted wait chain inserts or removes an entry in that single execute cycle.
// Reset is synchronous and active high: four free slots, none held, queue empty.
// The receiver cannot stall; each result is shown for exactly one cycle.
module priority_counting_semaphore_top #(
   parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [3:0] req_requester,
   input  logic [7:0] req_priority_req,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data,
   output logic       rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [3:0] rsp_granted_requester,
   output logic [7:0] rsp_available_slots,
   output logic [4:0] rsp_waiting_total,
   output logic [7:0] rsp_held_slots
);
   import pcs_pkg::*;

   pcs_cmd_type  cmd;
   pcs_stat_type stat;

   pcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pcs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_action            (req_action),
      .req_requester         (req_requester),
      .req_priority_req      (req_priority_req),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_granted_requester (rsp_granted_requester),
      .rsp_available_slots   (rsp_available_slots),
      .rsp_waiting_total     (rsp_waiting_total),
      .rsp_held_slots        (rsp_held_slots)
   );

endmodule

// ----- hw/rtl/pcs_checker.sv -----
module pcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_action,
   input logic [3:0] req_requester,
   input logic [7:0] req_priority_req,
   input logic       csr_write_en,
   input logic [7:0] csr_write_data,
   input logic       rsp_strobe,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_granted_requester,
   input logic [7:0] rsp_available_slots,
   input logic [4:0] rsp_waiting_total,
   input logic [7:0] rsp_held_slots
);
   import pcs_pkg::*;

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_busy_one : assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_strobe)
      else $error("execute cycle not followed by a result");

   a_strobe_src : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without an executed request");

   a_grant_id : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_GRANTED)
         |-> rsp_granted_requester == $past(req_requester, 2))
      else $error("immediate grant names the wrong requester");

   a_queued_nofree : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_QUEUED) |-> rsp_available_slots == 8'd0)
      else $error("request queued while a slot was free");

endmodule

bind priority_counting_semaphore_top pcs_checker u_pcs_checker (.*);
